@@ design/nsos_pkg.sv @@
// shared types, constants and the nibble reduction function for the order selector
// no dependencies; used by the controller, the datapath and the top level
`timescale 1ns / 1ps

package nsos_pkg;

  // widths fixed by the word fields
  localparam int unsigned ByteW   = 8;
  localparam int unsigned NibW    = 4;
  localparam int unsigned LenW    = 5;
  localparam int unsigned CntW    = 5;
  localparam int unsigned MaxOrderDefault = 16;

  localparam logic [LenW-1:0] OrderLenReset = 5'd11;
  localparam logic [NibW-1:0] NibbleMask    = 4'hF;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic take_lo;
    logic take_hi;
    logic fill_step;
    logic clear;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic seed_end;
    logic need_fill;
    logic fill_last_emit;
  } dp_status_t;

  // nibble modulo length, restoring reduction over four quotient bits
  function automatic logic [NibW-1:0] nib_mod(input logic [NibW-1:0] nib,
                                               input logic [LenW-1:0] len);
    logic [7:0] r;
    logic [7:0] d;
    r = {4'b0, nib};
    for (int i = 3; i >= 0; i--) begin
      d = {3'b0, len} << i;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[NibW-1:0];
  endfunction

endpackage

@@ design/nsos_dp.sv @@
// datapath of the order selector: length register, seen map, fill count, scan pointer
// and the output word register; depends on nsos_pkg
`timescale 1ns / 1ps

module nsos_dp #(
  parameter int unsigned MaxOrder = nsos_pkg::MaxOrderDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nsos_pkg::LenW-1:0]     cfg_wdata_i,
  input  logic [nsos_pkg::ByteW-1:0]    seed_byte_i,
  input  logic                          seed_end_i,
  input  nsos_pkg::ctrl_cmd_t           cmd_i,
  output nsos_pkg::dp_status_t          status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [nsos_pkg::NibW-1:0]     slot_value_o,
  output logic [nsos_pkg::NibW-1:0]     slot_position_o,
  output logic                          order_done_o
);

  logic [nsos_pkg::LenW-1:0]  cfg_q;
  logic [nsos_pkg::ByteW-1:0] byte_q;
  logic                       end_q;
  logic [MaxOrder-1:0]        seen_q, seen_d;
  logic [nsos_pkg::CntW-1:0]  count_q, count_d;
  logic [nsos_pkg::NibW-1:0]  scan_q;
  logic                       out_valid_q;
  logic [nsos_pkg::NibW-1:0]  out_value_q, out_pos_q;
  logic                       out_done_q;

  logic [nsos_pkg::LenW-1:0]  len;
  logic [nsos_pkg::NibW-1:0]  nib_sel, mod_v, cand_v;
  logic [MaxOrder-1:0]        cand_oh, len_mask, above_mask;
  logic                       is_seen, room, nib_emit, fill_emit, emit, fill_last, done;

  // effective length: zero reads as one, saturate at the map size
  always_comb begin
    if (cfg_q == '0) begin
      len = nsos_pkg::LenW'(1);
    end else if (cfg_q > nsos_pkg::LenW'(MaxOrder)) begin
      len = nsos_pkg::LenW'(MaxOrder);
    end else begin
      len = cfg_q;
    end
  end

  assign nib_sel = cmd_i.take_hi ? byte_q[7:4] : (byte_q[3:0] & nsos_pkg::NibbleMask);
  assign mod_v   = nsos_pkg::nib_mod(nib_sel, len);
  assign cand_v  = cmd_i.fill_step ? scan_q : mod_v;
  assign cand_oh = MaxOrder'(1) << cand_v;
  assign is_seen = |(seen_q & cand_oh);

  always_comb begin
    for (int i = 0; i < MaxOrder; i++) begin
      len_mask[i]   = (nsos_pkg::CntW'(i) < len);
      above_mask[i] = (nsos_pkg::CntW'(i) > {1'b0, scan_q});
    end
  end

  assign room      = (count_q < len);
  assign nib_emit  = (cmd_i.take_lo | cmd_i.take_hi) & room & ~is_seen;
  assign fill_emit = cmd_i.fill_step & ~is_seen;
  assign emit      = nib_emit | fill_emit;
  // no unseen value left above the scan point
  assign fill_last = ~|(~seen_q & len_mask & above_mask);
  assign done      = cmd_i.fill_step ? fill_last : ((count_q + 1'b1) == len);

  always_comb begin
    seen_d  = seen_q;
    count_d = count_q;
    if (cmd_i.clear) begin
      seen_d  = '0;
      count_d = '0;
    end else if (emit) begin
      seen_d  = seen_q | cand_oh;
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= nsos_pkg::OrderLenReset;
      seen_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      seen_q  <= seen_d;
      count_q <= count_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= seed_byte_i;
      end_q  <= seed_end_i;
      scan_q <= '0;
    end else if (cmd_i.fill_step) begin
      scan_q <= scan_q + 1'b1;
    end
    if (emit) begin
      out_value_q <= cand_v;
      out_pos_q   <= count_q[nsos_pkg::NibW-1:0];
      out_done_q  <= done;
    end
  end

  assign status_o.out_free       = ~out_valid_q | out_ready_i;
  assign status_o.seed_end       = end_q;
  assign status_o.need_fill      = room;
  assign status_o.fill_last_emit = fill_emit & fill_last;

  assign out_valid_o     = out_valid_q;
  assign slot_value_o    = out_value_q;
  assign slot_position_o = out_pos_q;
  assign order_done_o    = out_done_q;

endmodule

@@ design/nsos_ctrl.sv @@
// controller of the order selector: sequences low nibble, high nibble and the fill scan
// depends on nsos_pkg
`timescale 1ns / 1ps

module nsos_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  nsos_pkg::dp_status_t status_i,
  output nsos_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StLo,
    StHi,
    StEnd,
    StFill
  } state_e;

  state_e state_q;
  logic   rdy_q;

  always_comb begin
    cmd_o.accept    = rdy_q & in_valid_i;
    cmd_o.take_lo   = (state_q == StLo) & status_i.out_free;
    cmd_o.take_hi   = (state_q == StHi) & status_i.out_free;
    cmd_o.fill_step = (state_q == StFill) & status_i.out_free;
    cmd_o.clear     = ((state_q == StEnd) & ~status_i.need_fill) |
                      (cmd_o.fill_step & status_i.fill_last_emit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rdy_q   <= 1'b1;
    end else begin
      case (state_q)
        StIdle: begin
          if (cmd_o.accept) begin
            state_q <= StLo;
            rdy_q   <= 1'b0;
          end
        end
        StLo: begin
          if (status_i.out_free) begin
            state_q <= StHi;
          end
        end
        StHi: begin
          if (status_i.out_free) begin
            if (status_i.seed_end) begin
              state_q <= StEnd;
            end else begin
              state_q <= StIdle;
              rdy_q   <= 1'b1;
            end
          end
        end
        StEnd: begin
          if (status_i.need_fill) begin
            state_q <= StFill;
          end else begin
            state_q <= StIdle;
            rdy_q   <= 1'b1;
          end
        end
        StFill: begin
          if (cmd_o.fill_step && status_i.fill_last_emit) begin
            state_q <= StIdle;
            rdy_q   <= 1'b1;
          end
        end
        default: begin
          state_q <= StIdle;
          rdy_q   <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o = rdy_q;

endmodule

@@ design/nibble_seeded_order_selector_core.sv @@
// top level of the nibble seeded order selector: controller plus datapath
// depends on nsos_pkg, nsos_ctrl, nsos_dp
`timescale 1ns / 1ps
//
// channel   | direction | word contents (lowest bit first)
// ----------+-----------+--------------------------------------------------
// s_axis    | in        | tdata: seed_byte[7:0]; tlast: seed_end
// m_axis    | out       | tdata: slot_value[3:0], slot_position[7:4]; tlast: order_done
// cfg       | in        | cfg_wdata_i: order_length[4:0], written when cfg_we_i
//
// a seed byte is handled as accept, then low nibble, then high nibble
// the end byte adds a check step and, while values remain unchosen, a scan step
// per value from zero up to the highest unchosen one (at most 16), one value a cycle
// the output register frees the pipeline as soon as the word is taken; a stalled
// m_axis holds the sequencer at the next step that needs the output register
// reset (rst_ni, async low) clears the seen map and fill count, length returns to 11

module nibble_seeded_order_selector_core #(
  parameter int unsigned MaxOrder = nsos_pkg::MaxOrderDefault  // 2 .. 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration: order_length
  input  logic                      cfg_we_i,
  input  logic [nsos_pkg::LenW-1:0] cfg_wdata_i,
  // seed bytes
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // seed_byte[7:0]
  input  logic                      s_axis_tlast,   // seed_end
  // order entries
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // slot_value[3:0], slot_position[7:4]
  output logic                      m_axis_tlast    // order_done
);

  nsos_pkg::ctrl_cmd_t  cmd;
  nsos_pkg::dp_status_t status;
  logic [nsos_pkg::NibW-1:0] slot_value, slot_position;

  // state machine: one step per cycle, waits on the output register
  nsos_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // seen map, counters, nibble reduction and output word
  nsos_dp #(
    .MaxOrder (MaxOrder)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .seed_byte_i     (s_axis_tdata),
    .seed_end_i      (s_axis_tlast),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .slot_value_o    (slot_value),
    .slot_position_o (slot_position),
    .order_done_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {slot_position, slot_value};

endmodule

@@ design/nsos_checker.sv @@
// port level checks for the order selector, bound to the top level
// depends on nibble_seeded_order_selector_core
`timescale 1ns / 1ps

module nsos_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  // a stalled word keeps its contents
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // one seed byte at a time: ready drops after each accept
  a_one_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second byte accepted while the first is in work");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output word valid straight after reset");

endmodule

bind nibble_seeded_order_selector_core nsos_checker u_nsos_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

@@ tb/sv/nibble_seeded_order_selector_core_tb.sv @@
// self-checking testbench for nibble_seeded_order_selector_core: seed bytes in, order entries out
// depends on nsos_pkg and the core; holds its own model of the order builder
`timescale 1ns / 1ps

module nibble_seeded_order_selector_core_tb;

  // one order entry as it leaves the block
  typedef struct packed {
    logic [3:0] value;
    logic [3:0] position;
    logic       done;
  } slot_t;

  localparam int unsigned OrderMax    = 16;
  localparam int unsigned SettleWait  = 40;
  localparam int unsigned HoldCycles  = 200;   // long receiver hold-off
  localparam int unsigned StallLimit  = 2000;  // cycles without any handshake
  localparam int unsigned IdlePercent = 22;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [nsos_pkg::LenW-1:0] cfg_wdata_i = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata = '0;   // seed_byte[7:0]
  logic                      s_axis_tlast = 1'b0; // seed_end
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [7:0]                m_axis_tdata;        // slot_value[3:0], slot_position[7:4]
  logic                      m_axis_tlast;        // order_done

  // model state of the order builder
  logic [nsos_pkg::LenW-1:0] order_len_reg = nsos_pkg::OrderLenReset;
  logic [15:0]               seen_values = '0;
  int unsigned               placed_count = 0;
  slot_t                     pending_slots[$];

  // bookkeeping
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned words_checked = 0;
  int unsigned length_writes = 0;
  int unsigned stall_cycles = 0;
  slot_t       checked_slot;

  // idling control shared with the receiver process
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;

  nibble_seeded_order_selector_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // model: zero length acts as one, anything above sixteen saturates
  // ---------------------------------------------------------------------------
  function automatic int unsigned active_length();
    int unsigned len;
    len = order_len_reg;
    if (len == 0) len = 1;
    if (len > OrderMax) len = OrderMax;
    return len;
  endfunction

  // place both nibbles of an accepted byte, then fill on the end byte
  task automatic place_seed_byte(input logic [7:0] seed, input logic seed_end);
    int unsigned len;
    int unsigned v;
    logic [3:0]  nib;
    slot_t       s;
    slot_t       burst[$];
    len = active_length();
    for (int n = 0; n < 2; n++) begin
      nib = (n == 0) ? seed[3:0] : seed[7:4];
      if (placed_count < len) begin
        v = nib % len;
        if (!seen_values[v]) begin
          seen_values[v] = 1'b1;
          s.value    = v[3:0];
          s.position = placed_count[3:0];
          s.done     = (placed_count + 1 == len);
          burst.push_back(s);
          placed_count++;
        end
      end
    end
    if (seed_end) begin
      // a length cut below the count mid-seed leaves nothing to fill
      if (placed_count < len) begin
        for (v = 0; v < len; v++) begin
          if (!seen_values[v]) begin
            seen_values[v] = 1'b1;
            s.value    = v[3:0];
            s.position = placed_count[3:0];
            s.done     = 1'b0;
            burst.push_back(s);
            placed_count++;
          end
        end
        if (burst.size() > 0) burst[burst.size()-1].done = 1'b1;
      end
      seen_values  = '0;
      placed_count = 0;
    end
    foreach (burst[i]) pending_slots.push_back(burst[i]);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // offer one seed byte; valid stays high into the next call unless a gap is drawn
  task automatic send_seed_byte(input logic [7:0] seed, input logic seed_end);
    if (!calm && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= seed;
    s_axis_tlast  <= seed_end;
    do @(posedge clk_i); while (!s_axis_tready);
    place_seed_byte(seed, seed_end);
    bytes_sent++;
  endtask

  // sender stops until every expected word is back, then lets the core go quiet
  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic write_order_length(input logic [nsos_pkg::LenW-1:0] len);
    pause_until_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    order_len_reg = len;
    length_writes++;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random ready, calm stretches and a counted hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (calm) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= IdlePercent);
    end
  end

  // compare every accepted word with the oldest expected entry
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_slots.size() == 0) begin
        report_mismatch("unexpected word, tdata", m_axis_tdata, 0);
      end else begin
        checked_slot = pending_slots.pop_front();
        if (m_axis_tdata[3:0] != checked_slot.value)
          report_mismatch("slot_value", m_axis_tdata[3:0], checked_slot.value);
        if (m_axis_tdata[7:4] != checked_slot.position)
          report_mismatch("slot_position", m_axis_tdata[7:4], checked_slot.position);
        if (m_axis_tlast != checked_slot.done)
          report_mismatch("order_done", m_axis_tlast, checked_slot.done);
        words_checked++;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("timeout: no word moved for %0d cycles", StallLimit);
      $display("** nibble_seeded_order_selector_core: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // reset length of eleven, nibbles at both extremes, fill on the end byte
  task automatic test_reset_length();
    send_seed_byte(8'h00, 1'b0);
    send_seed_byte(8'hFF, 1'b0);
    send_seed_byte(8'hA5, 1'b0);
    send_seed_byte(8'h3C, 1'b1);
  endtask

  // full sixteen-entry order from the seed alone, positions up to fifteen;
  // bytes after completion and the end byte itself emit nothing
  task automatic test_complete_before_end();
    write_order_length(5'd16);
    for (int i = 0; i < 8; i++) send_seed_byte({4'(2*i+1), 4'(2*i)}, 1'b0);
    send_seed_byte(8'h00, 1'b0);
    send_seed_byte(8'hFF, 1'b1);
  endtask

  // zero length behaves as one, oversized length saturates at sixteen
  task automatic test_length_limits();
    write_order_length(5'd0);
    send_seed_byte(8'h00, 1'b1);
    send_seed_byte(8'h37, 1'b1);
    write_order_length(5'd31);
    send_seed_byte(8'h00, 1'b1);
  endtask

  // length changed in the middle of a seed, both downwards and upwards
  task automatic test_length_change_mid_seed();
    write_order_length(5'd16);
    send_seed_byte(8'h10, 1'b0);
    send_seed_byte(8'h32, 1'b0);
    send_seed_byte(8'h54, 1'b0);
    write_order_length(5'd4);      // six placed already: order counts as complete
    send_seed_byte(8'h76, 1'b0);
    send_seed_byte(8'h98, 1'b1);   // only clears
    write_order_length(5'd2);
    send_seed_byte(8'h00, 1'b0);
    write_order_length(5'd8);
    send_seed_byte(8'h11, 1'b1);
  endtask

  // receiver holds off for a long stretch while seed bytes keep coming
  task automatic test_output_hold_off();
    write_order_length(5'd16);
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) send_seed_byte(8'($urandom_range(255)), (i % 10) == 9);
    pause_until_drained();
  endtask

  // random seeds over a range of lengths; mostly well-formed seeds with one end
  // byte, some with end flags scattered at random
  task automatic test_random_seeds();
    logic [4:0]  lengths[9];
    int unsigned sent;
    int unsigned seed_len;
    bit          broken;
    lengths = '{5'd2, 5'd5, 5'd11, 5'd16, 5'd1, 5'd31, 5'd0, 5'd7, 5'd0};
    lengths[8] = 5'($urandom_range(31, 1));
    foreach (lengths[p]) begin
      write_order_length(lengths[p]);
      calm = (p == 3);             // one phase with no idling on either side
      sent = 0;
      while (sent < 52) begin
        seed_len = $urandom_range(8, 1);
        broken   = ($urandom_range(99) < 15);
        for (int b = 0; b < seed_len; b++) begin
          send_seed_byte(8'($urandom_range(255)),
                         broken ? 1'($urandom_range(1)) : (b == seed_len - 1));
          sent++;
        end
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_length();
    test_complete_before_end();
    test_length_limits();
    test_length_change_mid_seed();
    test_output_hold_off();
    test_random_seeds();

    pause_until_drained();
    $display("run covered %0d seed bytes and %0d order words over %0d length writes,",
             bytes_sent, words_checked, length_writes);
    $display("including mid-seed length changes, early completion and a long output stall");
    if (mismatches == 0) begin
      $display("** nibble_seeded_order_selector_core: PASSED **");
    end else begin
      $display("** nibble_seeded_order_selector_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/nsos_pkg.sv
design/nsos_dp.sv
design/nsos_ctrl.sv
design/nibble_seeded_order_selector_core.sv
design/nsos_checker.sv
tb/sv/nibble_seeded_order_selector_core_tb.sv
